/* hdl/vsr_pkg.sv */
// ----------------------------------------------------------------------------
// vsr_pkg
// Types and constants shared by the volume slew ramp modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vsr_pkg;

  localparam int TIME_BITS   = 32;
  localparam int LEVEL_BITS  = 14;
  localparam int QUOT_BITS   = 11;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_INDEX_W = 2;

  // reciprocal of ten, rounded down, scaled by 2^16
  localparam logic [12:0] RECIP_TEN    = 13'd6553;
  localparam int          RECIP_SHIFT  = 16;
  localparam logic [LEVEL_BITS-1:0] UNIT_TENTHS = LEVEL_BITS'(10);

  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_DOWN = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_DISCRETE_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_TENTHS     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SWEEP_RANGE     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_INTERVAL_S = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [13:0] requested_level;
    logic [31:0] now_seconds;
  } item_t;

  typedef struct packed {
    logic [1:0]  cmd_kind;
    logic [13:0] level_out;
    logic        in_sweep;
  } result_t;

  // registered request handed from the input stage to the core
  typedef struct packed {
    logic                  valid;
    logic                  tick;
    logic [13:0]           level;
    logic [31:0]           now;
    logic [QUOT_BITS-1:0]  quot;
  } stage_t;

endpackage

`default_nettype wire

/* hdl/vsr_prep.sv */
// ----------------------------------------------------------------------------
// vsr_prep
// Input register; also forms an estimate of the requested level over ten.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vsr_prep (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  input  wire vsr_pkg::item_t item,
  input  wire logic           advance,
  output vsr_pkg::stage_t     stage
);
  import vsr_pkg::*;

  logic                            accept;
  logic [LEVEL_BITS+13-1:0]        prod;

  assign item_stall = stage.valid && !advance;
  assign accept     = item_valid && !item_stall;

  // estimate is exact or one below the true quotient
  assign prod = LEVEL_BITS'(item.requested_level) * RECIP_TEN;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (accept) begin
      stage.valid <= 1'b1;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
    if (accept) begin
      stage.tick  <= item.req_type;
      stage.level <= item.requested_level;
      stage.now   <= item.now_seconds;
      stage.quot  <= prod[RECIP_SHIFT +: QUOT_BITS];
    end
  end

endmodule

`default_nettype wire

/* hdl/vsr_core.sv */
// ----------------------------------------------------------------------------
// vsr_core
// Level state, reset sweep control, configuration registers and result
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vsr_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire vsr_pkg::stage_t                     stage,
  output logic                                     advance,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output vsr_pkg::result_t                         result,
  input  wire logic                                cfg_we,
  input  wire logic [vsr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [vsr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import vsr_pkg::*;

  logic                  discrete_mode;
  logic [6:0]            step_tenths;
  logic [9:0]            sweep_range;
  logic [4:0]            zero_interval_s;

  logic [LEVEL_BITS-1:0] current_level, current_level_next;
  logic [LEVEL_BITS-1:0] target_level, target_level_next;
  logic                  sweeping, sweeping_next;
  logic [9:0]            sweep_count, sweep_count_next;
  logic [TIME_BITS-1:0]  last_zero_time, last_zero_time_next;
  logic                  emit;
  result_t               res_next;

  logic                  fire;
  logic [LEVEL_BITS-1:0] trunc_base, trunc_rem, trunc_level;
  logic [TIME_BITS-1:0]  now_t, elapsed;
  logic                  double_zero;
  logic [LEVEL_BITS-1:0] step, diff, moved;
  logic                  going_down;

  assign advance = !result_valid || !result_stall;
  assign fire    = stage.valid && advance;

  // truncate request to whole units, correcting the low quotient estimate
  assign trunc_base  = (LEVEL_BITS'(stage.quot) << 3) + (LEVEL_BITS'(stage.quot) << 1);
  assign trunc_rem   = stage.level - trunc_base;
  assign trunc_level = (trunc_rem >= UNIT_TENTHS) ? trunc_base + UNIT_TENTHS : trunc_base;

  assign now_t       = TIME_BITS'(stage.now);
  assign elapsed     = now_t - last_zero_time;
  assign double_zero = (zero_interval_s == 5'd0) ||
                       (elapsed <= TIME_BITS'(zero_interval_s));

  // slew step toward the target, clamped there
  always_comb begin
    if (discrete_mode) begin
      step = (step_tenths == 7'd0) ? LEVEL_BITS'(1) : LEVEL_BITS'(step_tenths);
    end else begin
      step = UNIT_TENTHS;
    end
    going_down = current_level > target_level;
    diff       = going_down ? current_level - target_level : target_level - current_level;
    if (diff > step) begin
      moved = going_down ? current_level - step : current_level + step;
    end else begin
      moved = target_level;
    end
  end

  always_comb begin
    current_level_next  = current_level;
    target_level_next   = target_level;
    sweeping_next       = sweeping;
    sweep_count_next    = sweep_count;
    last_zero_time_next = last_zero_time;
    emit                = 1'b0;
    res_next            = '0;
    if (!stage.tick) begin
      if (!sweeping) begin
        if (!discrete_mode && stage.level == '0) begin
          if (double_zero) begin
            sweeping_next    = 1'b1;
            sweep_count_next = sweep_range;
          end else begin
            last_zero_time_next = now_t;
          end
        end
        target_level_next = discrete_mode ? stage.level : trunc_level;
      end
    end else if (sweeping) begin
      if (sweep_count == '0) begin
        sweeping_next      = 1'b0;
        current_level_next = '0;
      end else begin
        sweep_count_next = sweep_count - 10'd1;
      end
      emit               = 1'b1;
      res_next.cmd_kind  = KIND_DOWN;
      res_next.level_out = current_level_next;
      res_next.in_sweep  = 1'b1;
    end else if (current_level != target_level) begin
      current_level_next = moved;
      emit               = 1'b1;
      res_next.level_out = moved;
      res_next.in_sweep  = 1'b0;
      if (discrete_mode) begin
        res_next.cmd_kind = KIND_SET;
      end else begin
        res_next.cmd_kind = going_down ? KIND_DOWN : KIND_UP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_level  <= '0;
      target_level   <= '0;
      sweeping       <= 1'b0;
      sweep_count    <= '0;
      last_zero_time <= '0;
    end else if (fire) begin
      current_level  <= current_level_next;
      target_level   <= target_level_next;
      sweeping       <= sweeping_next;
      sweep_count    <= sweep_count_next;
      last_zero_time <= last_zero_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      discrete_mode   <= 1'b0;
      step_tenths     <= 7'd10;
      sweep_range     <= 10'd100;
      zero_interval_s <= 5'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISCRETE_MODE:   discrete_mode   <= cfg_data[0];
        REG_STEP_TENTHS:     step_tenths     <= cfg_data[6:0];
        REG_SWEEP_RANGE:     sweep_range     <= cfg_data[9:0];
        REG_ZERO_INTERVAL_S: zero_interval_s <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sweep_is_down: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.in_sweep |-> result.cmd_kind == KIND_DOWN)
    else $error("sweep result is not a down command");

  a_sweep_end_zero: assert property (@(posedge clk) disable iff (rst)
    $fell(sweeping) |-> current_level == '0 && result_valid && result.level_out == '0)
    else $error("sweep ended without zero level");

  a_sweep_start_target: assert property (@(posedge clk) disable iff (rst)
    $rose(sweeping) |-> target_level == '0)
    else $error("sweep started with non-zero target");
`endif

endmodule

`default_nettype wire

/* hdl/volume_slew_ramp.sv */
// ----------------------------------------------------------------------------
// volume_slew_ramp
// Slew-limited volume level controller with stepped and discrete output.
// ----------------------------------------------------------------------------
// path: a tick's command passes through the input register, then the result register
// throughput: one request per cycle while the result is not stalled; the level update is a single pass
//   between the input register and the result register
// reset: synchronous; level, target, sweep and registers return to defaults
`timescale 1ns / 1ps
`default_nettype none

module volume_slew_ramp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire vsr_pkg::item_t                      item,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output vsr_pkg::result_t                         result,
  input  wire logic                                cfg_we,
  input  wire logic [vsr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [vsr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import vsr_pkg::*;

  stage_t stage;
  logic   advance;

  vsr_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .advance    (advance),
    .stage      (stage)
  );

  vsr_core u_core (
    .clk          (clk),
    .rst          (rst),
    .stage        (stage),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule

`default_nettype wire
